FILE: hw/rtl/shortest_queue_dispatcher_defines.svh
// Assertion macros for the shortest queue dispatcher checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef SHORTEST_QUEUE_DISPATCHER_DEFINES_SVH
`define SHORTEST_QUEUE_DISPATCHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SQD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dispatcher check failed");

// The consequent must hold in the cycle after the antecedent.
`define SQD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dispatcher check failed");

`endif

FILE: hw/rtl/sqd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sqd_pkg;

    localparam int NUM_QUEUES_DEF  = 4;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int CMD_W   = 2;
    localparam int SEL_W   = 2;
    localparam int STAMP_W = 16;
    localparam int COUNT_W = 8;
    localparam int ENTRY_W = STAMP_W + COUNT_W;
    localparam int QIDX_W  = 2;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = 5;

    localparam logic [CMD_W-1:0] CMD_OFFER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TAKE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

FILE: hw/rtl/shortest_queue_dispatcher.sv
// Join-shortest-queue dispatcher over NUM_QUEUES FIFO queues of QUEUE_DEPTH entries.
// Input channel (in_valid/in_ready) carries one command: offer places arrival_stamp
// and article_count at the tail of the shortest queue, lowest index on a tie; take
// removes and returns the head of queue_sel; peek returns it without removing it.
// Output channel (out_valid/out_ready) carries exactly one result per command, in
// order: queue_index, status (ok, empty, all full), the head fields and length_after.
// A result passes the read stage, then the output register. Up to one command is
// taken per cycle: queue lengths and pointers live in flip-flops beside the entry
// RAM, whose single registered read port sits between the two stages, so each command
// costs at most one RAM access and overlapping accesses never touch the same entry.
// When the receiver stalls, the result is held in the output register and one more
// command may sit in the read stage; in_ready then falls until the output moves.
// Reset clears all pointers, lengths and valid flags; the entry RAM is not cleared,
// as an entry is only read once it has been written.
`timescale 1ns / 1ps
`default_nettype none

module shortest_queue_dispatcher
    import sqd_pkg::*;
#(
    parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [CMD_W-1:0]   cmd,
    input  wire logic [SEL_W-1:0]   queue_sel,
    input  wire logic [STAMP_W-1:0] arrival_stamp,
    input  wire logic [COUNT_W-1:0] article_count,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [QIDX_W-1:0]       queue_index,
    output logic [STAT_W-1:0]       status,
    output logic [STAMP_W-1:0]      head_stamp,
    output logic [COUNT_W-1:0]      head_articles,
    output logic [LEN_W-1:0]        length_after
);

    localparam int QW        = $clog2(NUM_QUEUES);
    localparam int PW        = $clog2(QUEUE_DEPTH);
    localparam int LW        = $clog2(QUEUE_DEPTH + 1);
    localparam int RAM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW        = $clog2(RAM_DEPTH);

    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

    // Queue state
    logic [PW-1:0] head_reg [NUM_QUEUES];
    logic [PW-1:0] head_next [NUM_QUEUES];
    logic [PW-1:0] tail_reg [NUM_QUEUES];
    logic [PW-1:0] tail_next [NUM_QUEUES];
    logic [LW-1:0] len_reg [NUM_QUEUES];
    logic [LW-1:0] len_next [NUM_QUEUES];

    // Read stage
    logic              s1_valid_reg, s1_valid_next;
    logic [QIDX_W-1:0] s1_q_reg, s1_q_next;
    logic [STAT_W-1:0] s1_st_reg, s1_st_next;
    logic [LEN_W-1:0]  s1_len_reg, s1_len_next;
    logic              s1_hit_reg, s1_hit_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [QIDX_W-1:0]  out_q_reg, out_q_next;
    logic [STAT_W-1:0]  out_st_reg, out_st_next;
    logic [STAMP_W-1:0] out_stamp_reg, out_stamp_next;
    logic [COUNT_W-1:0] out_art_reg, out_art_next;
    logic [LEN_W-1:0]   out_len_reg, out_len_next;

    logic          accept;
    logic          s1_advance;
    logic [3:0]    sel_ext;
    logic [3:0]    sel_mod;
    logic [QW-1:0] sel_q;
    logic [LW-1:0] len_sel;
    logic [QW-1:0] best;
    logic [LW-1:0] best_len;
    logic          all_full;

    logic [QW-1:0]      res_q;
    logic [STAT_W-1:0]  res_st;
    logic [LW-1:0]      res_len;
    logic               res_hit;
    logic [QW+1:0]      res_q_pad;
    logic [LW+4:0]      res_len_pad;

    logic               ram_we;
    logic               ram_re;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    sqd_shortest #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_shortest (
        .lengths  (len_reg),
        .best     (best),
        .best_len (best_len),
        .all_full (all_full)
    );

    sqd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign accept     = in_valid && in_ready;

    // The selector is at most three, below twice any queue count of two or more, so one
    // conditional subtract reduces it.
    assign sel_ext = {2'b00, queue_sel};
    assign sel_mod = (sel_ext >= 4'(NUM_QUEUES)) ? sel_ext - 4'(NUM_QUEUES) : sel_ext;
    assign sel_q   = QW'(sel_mod);
    assign len_sel = len_reg[sel_q];

    assign ram_waddr = AW'(AW'(best) * AW'(QUEUE_DEPTH)) + AW'(tail_reg[best]);
    assign ram_raddr = AW'(AW'(sel_q) * AW'(QUEUE_DEPTH)) + AW'(head_reg[sel_q]);
    assign ram_wdata = {arrival_stamp, article_count};

    always_comb
    begin
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            head_next[q] = head_reg[q];
            tail_next[q] = tail_reg[q];
            len_next[q]  = len_reg[q];
        end
        ram_we  = 1'b0;
        ram_re  = 1'b0;
        res_q   = sel_q;
        res_st  = ST_OK;
        res_len = len_sel;
        res_hit = 1'b0;

        unique case (cmd) inside
            CMD_OFFER:
            begin
                if (all_full)
                begin
                    res_q   = '0;
                    res_st  = ST_FULL;
                    res_len = len_reg[0];
                end
                else
                begin
                    res_q   = best;
                    res_len = best_len + 1'b1;
                    if (accept)
                    begin
                        ram_we          = 1'b1;
                        tail_next[best] = (tail_reg[best] == PTR_LAST) ?
                                          '0 : tail_reg[best] + 1'b1;
                        len_next[best]  = best_len + 1'b1;
                    end
                end
            end
            CMD_TAKE, CMD_PEEK:
            begin
                if (len_sel == '0)
                begin
                    res_st  = ST_EMPTY;
                    res_len = '0;
                end
                else
                begin
                    res_hit = 1'b1;
                    ram_re  = accept;
                    if (cmd == CMD_TAKE)
                    begin
                        res_len = len_sel - 1'b1;
                        if (accept)
                        begin
                            head_next[sel_q] = (head_reg[sel_q] == PTR_LAST) ?
                                               '0 : head_reg[sel_q] + 1'b1;
                            len_next[sel_q]  = len_sel - 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Results are reported in the fixed port widths, keeping the low bits.
    assign res_q_pad   = {2'b00, res_q};
    assign res_len_pad = {5'b00000, res_len};

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_q_next     = s1_q_reg;
        s1_st_next    = s1_st_reg;
        s1_len_next   = s1_len_reg;
        s1_hit_next   = s1_hit_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            s1_q_next     = res_q_pad[QIDX_W-1:0];
            s1_st_next    = res_st;
            s1_len_next   = res_len_pad[LEN_W-1:0];
            s1_hit_next   = res_hit;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_q_next     = out_q_reg;
        out_st_next    = out_st_reg;
        out_stamp_next = out_stamp_reg;
        out_art_next   = out_art_reg;
        out_len_next   = out_len_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
            out_q_next     = s1_q_reg;
            out_st_next    = s1_st_reg;
            out_stamp_next = s1_hit_reg ? ram_rdata[ENTRY_W-1:COUNT_W] : '0;
            out_art_next   = s1_hit_reg ? ram_rdata[COUNT_W-1:0] : '0;
            out_len_next   = s1_len_reg;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                head_reg[q] <= '0;
                tail_reg[q] <= '0;
                len_reg[q]  <= '0;
            end
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                head_reg[q] <= head_next[q];
                tail_reg[q] <= tail_next[q];
                len_reg[q]  <= len_next[q];
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_q_reg      <= s1_q_next;
        s1_st_reg     <= s1_st_next;
        s1_len_reg    <= s1_len_next;
        s1_hit_reg    <= s1_hit_next;
        out_q_reg     <= out_q_next;
        out_st_reg    <= out_st_next;
        out_stamp_reg <= out_stamp_next;
        out_art_reg   <= out_art_next;
        out_len_reg   <= out_len_next;
    end

    assign out_valid     = out_valid_reg;
    assign queue_index   = out_q_reg;
    assign status        = out_st_reg;
    assign head_stamp    = out_stamp_reg;
    assign head_articles = out_art_reg;
    assign length_after  = out_len_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/sqd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sqd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
)(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/sqd_shortest.sv
`timescale 1ns / 1ps
`default_nettype none

module sqd_shortest #(
    parameter int NUM_QUEUES  = 4,
    parameter int QUEUE_DEPTH = 16
)(
    input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0] lengths [NUM_QUEUES],
    output logic      [$clog2(NUM_QUEUES)-1:0]    best,
    output logic      [$clog2(QUEUE_DEPTH+1)-1:0] best_len,
    output logic                                  all_full
);

    localparam int QW = $clog2(NUM_QUEUES);
    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    // A strict less-than keeps the lowest index on a tie.
    always_comb
    begin
        best     = '0;
        best_len = lengths[0];
        for (int q = 1; q < NUM_QUEUES; q++)
        begin
            if (lengths[q] < best_len)
            begin
                best     = QW'(q);
                best_len = lengths[q];
            end
        end
    end

    assign all_full = (best_len >= LW'(QUEUE_DEPTH));

endmodule

`default_nettype wire

FILE: hw/rtl/sqd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "shortest_queue_dispatcher_defines.svh"

module sqd_checker
    import sqd_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [QIDX_W-1:0]  queue_index,
    input wire logic [STAT_W-1:0]  status,
    input wire logic [STAMP_W-1:0] head_stamp,
    input wire logic [COUNT_W-1:0] head_articles,
    input wire logic [LEN_W-1:0]   length_after
);

    // A stalled result keeps its valid flag and its fields.
    `SQD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(queue_index) && $stable(status) && $stable(head_stamp) && $stable(head_articles) && $stable(length_after))

    // Input back-pressure only ever comes from a stalled output.
    `SQD_ASSERT_SAME(a_stall_source, !in_ready, out_valid && !out_ready)

    // An empty queue reports no head and no entries.
    `SQD_ASSERT_SAME(a_empty_result, out_valid && (status == ST_EMPTY), head_stamp == '0 && head_articles == '0 && length_after == '0)

    // A refused offer reports queue zero without head data.
    `SQD_ASSERT_SAME(a_full_result, out_valid && (status == ST_FULL), queue_index == '0 && head_stamp == '0 && head_articles == '0)

endmodule

bind shortest_queue_dispatcher sqd_checker u_sqd_checker (.*);

`default_nettype wire

FILE: test/shortest_queue_dispatcher_tb.sv
`timescale 1ns / 1ps

module shortest_queue_dispatcher_tb;
    import sqd_pkg::*;

    localparam int NQ    = NUM_QUEUES_DEF;
    localparam int DEPTH = QUEUE_DEPTH_DEF;

    // Command code that the block decodes as a no-op.
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [SEL_W-1:0]   sel;
        logic [STAMP_W-1:0] stamp;
        logic [COUNT_W-1:0] count;
    } command_t;

    typedef struct packed {
        logic [QIDX_W-1:0]  queue_index;
        logic [STAT_W-1:0]  status;
        logic [STAMP_W-1:0] head_stamp;
        logic [COUNT_W-1:0] head_articles;
        logic [LEN_W-1:0]   length_after;
    } outcome_t;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [CMD_W-1:0]   cmd = '0;
    logic [SEL_W-1:0]   queue_sel = '0;
    logic [STAMP_W-1:0] arrival_stamp = '0;
    logic [COUNT_W-1:0] article_count = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [QIDX_W-1:0]  queue_index;
    logic [STAT_W-1:0]  status;
    logic [STAMP_W-1:0] head_stamp;
    logic [COUNT_W-1:0] head_articles;
    logic [LEN_W-1:0]   length_after;

    command_t command_backlog[$];
    outcome_t dispatch_outcomes[$];
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       fail_count = 0;

    // Shadow copy of the queues.
    logic [ENTRY_W-1:0] slot_mem [NQ][DEPTH];
    int                 rd_ptr [NQ];
    int                 wr_ptr [NQ];
    int                 fill [NQ];

    shortest_queue_dispatcher i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .queue_sel    (queue_sel),
        .arrival_stamp(arrival_stamp),
        .article_count(article_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .queue_index  (queue_index),
        .status       (status),
        .head_stamp   (head_stamp),
        .head_articles(head_articles),
        .length_after (length_after)
    );

    always #2 clk = ~clk;

    function automatic outcome_t apply_command(command_t c);
        outcome_t o;
        int       best;
        int       q;
        o = '0;
        q = int'(c.sel) % NQ;
        case (c.cmd)
            CMD_OFFER:
            begin
                best = 0;
                for (int i = 1; i < NQ; i++)
                begin
                    if (fill[i] < fill[best])
                        best = i;
                end
                if (fill[best] >= DEPTH)
                begin
                    o.status       = ST_FULL;
                    o.length_after = LEN_W'(fill[0]);
                end
                else
                begin
                    slot_mem[best][wr_ptr[best]] = {c.stamp, c.count};
                    wr_ptr[best] = (wr_ptr[best] + 1) % DEPTH;
                    fill[best]++;
                    o.queue_index  = QIDX_W'(best);
                    o.status       = ST_OK;
                    o.length_after = LEN_W'(fill[best]);
                end
            end
            CMD_TAKE, CMD_PEEK:
            begin
                o.queue_index = QIDX_W'(q);
                if (fill[q] == 0)
                    o.status = ST_EMPTY;
                else
                begin
                    {o.head_stamp, o.head_articles} = slot_mem[q][rd_ptr[q]];
                    if (c.cmd == CMD_TAKE)
                    begin
                        rd_ptr[q] = (rd_ptr[q] + 1) % DEPTH;
                        fill[q]--;
                    end
                    o.status       = ST_OK;
                    o.length_after = LEN_W'(fill[q]);
                end
            end
            default:
            begin
                o.queue_index  = QIDX_W'(q);
                o.status       = ST_OK;
                o.length_after = LEN_W'(fill[q]);
            end
        endcase
        return o;
    endfunction

    // Driver: the payload only changes once the previous transfer has happened.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                dispatch_outcomes.push_back(apply_command({cmd, queue_sel,
                                                           arrival_stamp, article_count}));
            if (!in_valid || in_ready)
            begin
                if (command_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    command_t c;
                    c = command_backlog.pop_front();
                    cmd           <= c.cmd;
                    queue_sel     <= c.sel;
                    arrival_stamp <= c.stamp;
                    article_count <= c.count;
                    in_valid      <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (dispatch_outcomes.size() == 0)
                begin
                    $error("result transfer with nothing outstanding");
                    fail_count++;
                end
                else
                begin
                    outcome_t w;
                    w = dispatch_outcomes.pop_front();
                    if (queue_index !== w.queue_index)
                    begin
                        $error("queue_index expected %0d actual %0d", w.queue_index,
                               queue_index);
                        fail_count++;
                    end
                    if (status !== w.status)
                    begin
                        $error("status expected %0d actual %0d", w.status, status);
                        fail_count++;
                    end
                    if (head_stamp !== w.head_stamp)
                    begin
                        $error("head_stamp expected %h actual %h", w.head_stamp,
                               head_stamp);
                        fail_count++;
                    end
                    if (head_articles !== w.head_articles)
                    begin
                        $error("head_articles expected %h actual %h", w.head_articles,
                               head_articles);
                        fail_count++;
                    end
                    if (length_after !== w.length_after)
                    begin
                        $error("length_after expected %0d actual %0d", w.length_after,
                               length_after);
                        fail_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_command(logic [CMD_W-1:0] c, logic [SEL_W-1:0] s,
                                 logic [STAMP_W-1:0] st, logic [COUNT_W-1:0] n);
        command_backlog.push_back({c, s, st, n});
    endtask

    // Bursts of offer-heavy and take-heavy traffic push the queues to full and
    // back to empty again, so both special cases turn up often.
    task automatic queue_random_traffic(int n);
        traffic_mix_t mix;
        int           burst;
        int           offer_cut;
        int           take_cut;
        int           peek_cut;
        int           r;
        logic [CMD_W-1:0] c;
        while (n > 0)
        begin
            mix   = traffic_mix_t'($urandom_range(2));
            burst = $urandom_range(30, 140);
            case (mix)
                MIX_FILL:  begin offer_cut = 85; take_cut = 93; peek_cut = 98; end
                MIX_DRAIN: begin offer_cut = 15; take_cut = 80; peek_cut = 95; end
                default:   begin offer_cut = 45; take_cut = 80; peek_cut = 95; end
            endcase
            for (int i = 0; i < burst && n > 0; i++)
            begin
                r = $urandom_range(99);
                if (r < offer_cut)
                    c = CMD_OFFER;
                else if (r < take_cut)
                    c = CMD_TAKE;
                else if (r < peek_cut)
                    c = CMD_PEEK;
                else
                    c = CMD_SPARE;
                queue_command(c, SEL_W'($urandom_range(3)), STAMP_W'($urandom_range(65535)),
                              COUNT_W'($urandom_range(255)));
                n--;
            end
        end
    endtask

    initial
    begin
        for (int q = 0; q < NQ; q++)
        begin
            rd_ptr[q] = 0;
            wr_ptr[q] = 0;
            fill[q]   = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Extremes of the fields, every command, empty queues and the spare code.
        queue_command(CMD_PEEK,  2'd0, 16'h0000, 8'h00);
        queue_command(CMD_TAKE,  2'd3, 16'hFFFF, 8'hFF);
        queue_command(CMD_SPARE, 2'd0, 16'h0000, 8'h00);
        queue_command(CMD_OFFER, 2'd3, 16'h0000, 8'h00);
        queue_command(CMD_OFFER, 2'd0, 16'hFFFF, 8'hFF);
        queue_command(CMD_OFFER, 2'd1, 16'hAAAA, 8'h55);
        queue_command(CMD_OFFER, 2'd2, 16'h5555, 8'hAA);
        queue_command(CMD_OFFER, 2'd3, 16'h8001, 8'h80);
        queue_command(CMD_SPARE, 2'd3, 16'hFFFF, 8'hFF);
        queue_command(CMD_PEEK,  2'd0, 16'h1234, 8'h12);
        queue_command(CMD_PEEK,  2'd1, 16'h0000, 8'h00);
        queue_command(CMD_PEEK,  2'd2, 16'hFFFF, 8'hFF);
        queue_command(CMD_PEEK,  2'd3, 16'h0000, 8'h00);
        queue_command(CMD_TAKE,  2'd1, 16'h0000, 8'h00);
        queue_command(CMD_TAKE,  2'd1, 16'hFFFF, 8'hFF);
        queue_command(CMD_OFFER, 2'd2, 16'h0001, 8'h01);
        queue_command(CMD_TAKE,  2'd0, 16'h0000, 8'h00);
        queue_command(CMD_TAKE,  2'd2, 16'h0000, 8'h00);
        queue_command(CMD_TAKE,  2'd3, 16'h0000, 8'h00);
        queue_command(CMD_TAKE,  2'd0, 16'h0000, 8'h00);
        queue_command(CMD_TAKE,  2'd1, 16'h0000, 8'h00);
        queue_command(CMD_TAKE,  2'd2, 16'h0000, 8'h00);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            queue_random_traffic(412);
            while (command_backlog.size() > 0 || in_valid || dispatch_outcomes.size() > 0)
                @(negedge clk);
        end

        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("shortest_queue_dispatcher_tb: clean");
        else
            $display("shortest_queue_dispatcher_tb: errors");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("shortest_queue_dispatcher_tb: errors");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/sqd_pkg.sv
hw/rtl/sqd_ram.sv
hw/rtl/sqd_shortest.sv
hw/rtl/shortest_queue_dispatcher.sv
hw/rtl/sqd_checker.sv
test/shortest_queue_dispatcher_tb.sv
